// ----- rtl/agtcf_pkg.sv -----
package agtcf_pkg;

   localparam int IN_W       = 16;
   localparam int AX_W       = 17;
   localparam int OUT_W      = 24;
   localparam int ALPHA_W    = 16;
   localparam int PERIOD_W   = 20;
   localparam int CW         = 38;
   localparam int ZW         = 26;
   localparam int ANG_SH     = 8;
   localparam int ACC_ANG_W  = ZW - ANG_SH;
   localparam int XY_SH      = 16;
   localparam int MAG_SH     = 8;
   localparam int MAG_W      = 24;
   localparam int RAD_W      = 2 * MAG_W;
   localparam int REM_W      = MAG_W + 2;
   localparam int SQRT_STEPS = MAG_W;
   localparam int SQRT_CNT_W = 5;
   localparam int SUMSQ_W    = 32;
   localparam int MA_W       = 18;
   localparam int MB_W       = 37;
   localparam int PROD_W     = MA_W + MB_W;
   localparam int MACC_W     = 60;
   localparam int BLEND_SH   = 17;
   localparam int RES_SH     = 33;
   localparam int RES_W      = MACC_W - RES_SH;
   localparam int ATAN_LEN   = 24;
   localparam int ATAN_IDX_W = 5;
   localparam int ATAN_W     = 22;
   localparam int CFG_IDX_W  = 2;
   localparam int CFG_DATA_W = 20;

   localparam logic [CFG_IDX_W-1:0] CSR_ALPHA  = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CSR_PERIOD = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CSR_ROTATE = 2'd2;

   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd64225;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd2097;
   localparam logic [ALPHA_W:0]    ALPHA_ONE    = 17'd65536;

   localparam logic signed [ZW-1:0] DEG90    = 26'sd5898240;
   localparam logic signed [ZW-1:0] ANG_HALF = 26'sd128;

   typedef struct packed {
      logic signed [IN_W-1:0] accel_x_raw;
      logic signed [IN_W-1:0] accel_y_raw;
      logic signed [IN_W-1:0] accel_z_raw;
      logic signed [IN_W-1:0] rate_roll;
      logic signed [IN_W-1:0] rate_pitch;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] roll_angle;
      logic signed [OUT_W-1:0] pitch_angle;
   } rsp_type;

   typedef enum logic [1:0] {
      MAC_NONE  = 2'd0,
      MAC_LOAD  = 2'd1,
      MAC_ADD   = 2'd2,
      MAC_ADDSH = 2'd3
   } mac_op_type;

   typedef struct packed {
      mac_op_type             op;
      logic signed [MA_W-1:0] a;
      logic signed [MB_W-1:0] b;
   } mac_req_type;

   typedef struct packed {
      logic                 start;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } cordic_req_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      v = '0;
      unique case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/agtcf_mac.sv -----
module agtcf_mac (
   input  logic                                    clock,
   input  logic                                    reset,
   input  agtcf_pkg::mac_req_type                  req,
   output logic signed [agtcf_pkg::MACC_W-1:0]     acc
);
   import agtcf_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   mac_op_type               op_ff;
   logic signed [MACC_W-1:0] acc_ff, acc_in;

   assign prod_in = PROD_W'(req.a) * PROD_W'(req.b);

   always_comb begin
      unique case (op_ff)
         MAC_NONE:  acc_in = acc_ff;
         MAC_LOAD:  acc_in = MACC_W'(prod_ff);
         MAC_ADD:   acc_in = acc_ff + MACC_W'(prod_ff);
         MAC_ADDSH: acc_in = acc_ff + {prod_ff[MACC_W-BLEND_SH-1:0], {BLEND_SH{1'b0}}};
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= MAC_NONE;
      end else begin
         op_ff <= req.op;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- rtl/agtcf_isqrt.sv -----
module agtcf_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [agtcf_pkg::RAD_W-1:0]     rad,
   output logic                            busy,
   output logic [agtcf_pkg::MAG_W-1:0]     root
);
   import agtcf_pkg::*;

   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [MAG_W-1:0]      root_ff, root_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [REM_W+1:0]      rem2, trial, diff;
   logic                  ge;

   assign rem2  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign ge    = rem2 >= trial;
   assign diff  = rem2 - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
         root_in = {root_ff[MAG_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ----- rtl/agtcf_cordic.sv -----
module agtcf_cordic #(
   parameter int NITER = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  agtcf_pkg::cordic_req_type                req,
   output logic                                     busy,
   output logic signed [agtcf_pkg::ACC_ANG_W-1:0]   angle
);
   import agtcf_pkg::*;

   localparam int IW = (NITER > 1) ? $clog2(NITER) : 1;

   logic signed [CW-1:0]        x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ZW-1:0]        z_ff, z_in, at, zr;
   logic [IW-1:0]               iter_ff, iter_in;
   logic                        busy_ff, busy_in, fin_ff, fin_in, ypos;
   logic signed [ACC_ANG_W-1:0] angle_ff, angle_in;

   assign xs   = x_ff >>> iter_ff;
   assign ys   = y_ff >>> iter_ff;
   assign ypos = !y_ff[CW-1] && (y_ff != '0);
   assign at   = ZW'(atan_q16(ATAN_IDX_W'(iter_ff)));
   assign zr   = z_ff + ANG_HALF;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      iter_in  = iter_ff;
      busy_in  = busy_ff;
      fin_in   = fin_ff;
      angle_in = angle_ff;
      if (req.start) begin
         iter_in = '0;
         fin_in  = 1'b0;
         if ((req.x == '0) && (req.y == '0)) begin
            angle_in = '0;
            busy_in  = 1'b0;
         end else begin
            busy_in = 1'b1;
            if (!req.x[CW-1]) begin
               x_in = req.x;
               y_in = req.y;
               z_in = '0;
            end else if (!req.y[CW-1]) begin
               x_in = req.y;
               y_in = -req.x;
               z_in = DEG90;
            end else begin
               x_in = -req.y;
               y_in = req.x;
               z_in = -DEG90;
            end
         end
      end else if (fin_ff) begin
         angle_in = zr[ZW-1:ANG_SH];
         busy_in  = 1'b0;
         fin_in   = 1'b0;
      end else if (busy_ff) begin
         if (ypos) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end
         if (iter_ff == IW'(NITER - 1)) begin
            fin_in = 1'b1;
         end else begin
            iter_in = iter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      iter_ff  <= iter_in;
      angle_ff <= angle_in;
   end

   assign busy  = busy_ff;
   assign angle = angle_ff;

endmodule

// ----- rtl/accel_gyro_tilt_complementary_filter.sv -----
// Roll/pitch tilt estimator, one IMU sample per request beat.
// req channel: valid/ready, req_data carries three accel counts and two gyro rates.
// rsp channel: valid/ready, rsp_data carries the filtered roll and pitch angles
// in 1/256 degree, saturated to 24 bits. One response beat per request beat.
// csr channel: valid/ready write port, csr_index selects alpha_weight (0),
// sample_period (1) or rotate_mount (2); other indexes are dropped. Always ready.
// One sample is processed at a time; req_ready is high only while idle.
// From request beat to response valid, a sample passes through the squares,
// a 24-step bit-serial square root (overlapping the roll CORDIC pass), the
// launch of the pitch CORDIC pass, that pass on the shared rotation stage,
// the shared multiply-accumulate for the two blends and the load of the
// response register.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next result waits in the final state
// until the register frees.
// Synchronous reset clears the angle estimates to zero, restores the register
// defaults and leaves both channels empty.
module accel_gyro_tilt_complementary_filter #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  agtcf_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output agtcf_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [agtcf_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [agtcf_pkg::CFG_DATA_W-1:0]     csr_wdata
);
   import agtcf_pkg::*;

   localparam int N_ITER = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SQR   = 6'b000010,
      ST_ROOT  = 6'b000100,
      ST_PITCH = 6'b001000,
      ST_BLEND = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [ALPHA_W-1:0]          alpha_ff, alpha_in;
   logic [PERIOD_W-1:0]         period_ff, period_in;
   logic                        rotate_ff, rotate_in;
   logic signed [AX_W-1:0]      ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [IN_W-1:0]      gr_ff, gr_in, gp_ff, gp_in;
   logic [1:0]                  sq_cnt_ff, sq_cnt_in;
   logic [2:0]                  phase_ff, phase_in;
   logic                        sel_ff, sel_in;
   logic signed [ACC_ANG_W-1:0] roll_grav_ff, roll_grav_in;
   logic signed [OUT_W-1:0]     roll_est_ff, roll_est_in, pitch_est_ff, pitch_est_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   mac_req_type                 mac_req;
   logic signed [MACC_W-1:0]    mac_acc;
   cordic_req_type              cordic_req;
   logic                        cordic_busy;
   logic signed [ACC_ANG_W-1:0] cordic_angle;
   logic                        sqrt_start, sqrt_busy;
   logic [RAD_W-1:0]            sqrt_rad;
   logic [MAG_W-1:0]            sqrt_root;

   logic signed [OUT_W-1:0]     old_sel;
   logic signed [IN_W-1:0]      rate_sel;
   logic signed [ACC_ANG_W-1:0] ang_sel;
   logic [ALPHA_W:0]            beta;
   logic signed [RES_W-1:0]     r_sum;
   logic signed [OUT_W-1:0]     r_sat;
   logic                        accept, can_load;

   agtcf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .acc   (mac_acc)
   );

   agtcf_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .rad   (sqrt_rad),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   agtcf_cordic #(.NITER(N_ITER)) u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .busy  (cordic_busy),
      .angle (cordic_angle)
   );

   assign accept   = req_valid && req_ready;
   assign can_load = !rsp_valid_ff || rsp_ready;
   assign beta     = ALPHA_ONE - (ALPHA_W + 1)'(alpha_ff);
   assign old_sel  = sel_ff ? pitch_est_ff : roll_est_ff;
   assign rate_sel = sel_ff ? gp_ff : gr_ff;
   assign ang_sel  = sel_ff ? cordic_angle : roll_grav_ff;
   assign sqrt_rad = {mac_acc[SUMSQ_W-1:0], {(RAD_W - SUMSQ_W){1'b0}}};

   // round half up then clamp to the output range
   assign r_sum = mac_acc[MACC_W-1:RES_SH] + RES_W'(mac_acc[RES_SH-1]);

   always_comb begin
      if (!r_sum[RES_W-1] && (r_sum[RES_W-2:OUT_W-1] != '0)) begin
         r_sat = {1'b0, {(OUT_W - 1){1'b1}}};
      end else if (r_sum[RES_W-1] && (r_sum[RES_W-2:OUT_W-1] != '1)) begin
         r_sat = {1'b1, {(OUT_W - 1){1'b0}}};
      end else begin
         r_sat = r_sum[OUT_W-1:0];
      end
   end

   always_comb begin
      alpha_in  = alpha_ff;
      period_in = period_ff;
      rotate_in = rotate_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA:  alpha_in  = csr_wdata[ALPHA_W-1:0];
            CSR_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            CSR_ROTATE: rotate_in = csr_wdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      gr_in        = gr_ff;
      gp_in        = gp_ff;
      sq_cnt_in    = sq_cnt_ff;
      phase_in     = phase_ff;
      sel_in       = sel_ff;
      roll_grav_in = roll_grav_ff;
      roll_est_in  = roll_est_ff;
      pitch_est_in = pitch_est_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      mac_req      = '{op: MAC_NONE, a: '0, b: '0};
      cordic_req   = '{start: 1'b0, x: '0, y: '0};
      sqrt_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (rotate_ff) begin
                  ax_in = AX_W'(req_data.accel_y_raw);
                  ay_in = -AX_W'(req_data.accel_x_raw);
               end else begin
                  ax_in = AX_W'(req_data.accel_x_raw);
                  ay_in = AX_W'(req_data.accel_y_raw);
               end
               az_in     = AX_W'(req_data.accel_z_raw);
               gr_in     = req_data.rate_roll;
               gp_in     = req_data.rate_pitch;
               sq_cnt_in = '0;
               state_in  = ST_SQR;
            end
         end
         ST_SQR: begin
            sq_cnt_in = sq_cnt_ff + 1'b1;
            unique case (sq_cnt_ff)
               2'd0: begin
                  mac_req    = '{op: MAC_LOAD, a: MA_W'(ay_ff), b: MB_W'(ay_ff)};
                  cordic_req = '{start: 1'b1,
                                 x: CW'(az_ff) <<< XY_SH,
                                 y: CW'(ay_ff) <<< XY_SH};
               end
               2'd1: begin
                  mac_req = '{op: MAC_ADD, a: MA_W'(az_ff), b: MB_W'(az_ff)};
               end
               2'd2: ;
               2'd3: begin
                  sqrt_start = 1'b1;
                  state_in   = ST_ROOT;
               end
               default: ;
            endcase
         end
         ST_ROOT: begin
            if (!cordic_busy && !sqrt_busy) begin
               roll_grav_in = cordic_angle;
               cordic_req   = '{start: 1'b1,
                                x: CW'({sqrt_root, {MAG_SH{1'b0}}}),
                                y: -(CW'(ax_ff) <<< XY_SH)};
               state_in     = ST_PITCH;
            end
         end
         ST_PITCH: begin
            if (!cordic_busy) begin
               phase_in = '0;
               sel_in   = 1'b0;
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            phase_in = phase_ff + 1'b1;
            unique case (phase_ff)
               3'd0: mac_req = '{op: MAC_LOAD, a: MA_W'(rate_sel), b: MB_W'(period_ff)};
               3'd2: mac_req = '{op: MAC_LOAD, a: MA_W'(alpha_ff), b: mac_acc[MB_W-1:0]};
               3'd3: mac_req = '{op: MAC_ADDSH, a: MA_W'(alpha_ff), b: MB_W'(old_sel)};
               3'd4: mac_req = '{op: MAC_ADDSH, a: MA_W'(beta), b: MB_W'(ang_sel)};
               3'd6: begin
                  phase_in = '0;
                  if (sel_ff) begin
                     pitch_est_in = r_sat;
                     state_in     = ST_DONE;
                  end else begin
                     roll_est_in = r_sat;
                     sel_in      = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_data_in  = '{roll_angle: roll_est_ff, pitch_angle: pitch_est_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= ALPHA_RESET;
         period_ff    <= PERIOD_RESET;
         rotate_ff    <= 1'b0;
         roll_est_ff  <= '0;
         pitch_est_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         period_ff    <= period_in;
         rotate_ff    <= rotate_in;
         roll_est_ff  <= roll_est_in;
         pitch_est_ff <= pitch_est_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      az_ff        <= az_in;
      gr_ff        <= gr_in;
      gp_ff        <= gp_in;
      sq_cnt_ff    <= sq_cnt_in;
      phase_ff     <= phase_in;
      sel_ff       <= sel_in;
      roll_grav_ff <= roll_grav_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// ----- rtl/agtcf_checker.sv -----
module agtcf_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input agtcf_pkg::rsp_type  rsp_data
);

   // held response beat keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one sample in flight: a request beat closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a response is produced only from the busy phase
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without a sample");

   // reset leaves input open and output empty
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("bad state after reset");

endmodule

bind accel_gyro_tilt_complementary_filter agtcf_checker u_agtcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
